// ----- rtl/nid_pkg.sv -----
// Package for the normalized image difference block.
// Holds the sequencer state type, register indexes and fixed widths.
// No dependencies.
package nid_pkg;

   localparam int MAX_DIMENSION_DEFAULT = 4096;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int SUM_BITS  = 40;
   localparam int SUM_HALF  = 20;
   localparam int TOL_BITS  = 14;
   localparam int X_BITS    = SUM_BITS + TOL_BITS;
   localparam int CFG_BITS  = 14;
   localparam int DIM_PORT_BITS = 13;
   localparam int PERCENT_SCALE = 10000;

   localparam logic [1:0] REG_WIDTH     = 2'd0;
   localparam logic [1:0] REG_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_ALPHA     = 2'd2;
   localparam logic [1:0] REG_TOLERANCE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RATIO,
      ST_SQUARE,
      ST_ACCUM_SQ,
      ST_ROOT,
      ST_LEVEL,
      ST_PIX_MUL,
      ST_PIX_LOAD,
      ST_XLO_MUL,
      ST_XLO_ADD,
      ST_XHI_MUL,
      ST_XHI_ADD,
      ST_REPORT_DIV,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/normalized_image_difference.sv -----
// Normalized RGBA image difference: one pixel pair in, one grey level out, with
// an image summary on the final pixel. Depends on nid_pkg.
//
// Each item takes a pixel pair and produces one result item. The divides and the
// square root share one subtractor (restoring divide and square root, one bit a
// cycle), and the products one registered multiplier, under a sequencer; the block
// stalls its input while an item is in work. With alpha, a fourth channel is added.
// The final pixel also computes the pixel count and the scaled sum, and runs the
// report divide. A finished result waits in an output register, so the next item
// may enter while it is not yet taken; the sequencer holds only when a second
// result is ready while the first is still stalled. Configuration writes are
// always ready.
module normalized_image_difference #(
   parameter int MAX_DIMENSION          = nid_pkg::MAX_DIMENSION_DEFAULT,
   parameter int DISTANCE_FRACTION_BITS = nid_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_actual_red,
   input  logic [7:0]  req_actual_green,
   input  logic [7:0]  req_actual_blue,
   input  logic [7:0]  req_actual_alpha,
   input  logic [7:0]  req_base_red,
   input  logic [7:0]  req_base_green,
   input  logic [7:0]  req_base_blue,
   input  logic [7:0]  req_base_alpha,
   input  logic        req_final_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_diff_level,
   output logic        rsp_report_valid,
   output logic [13:0] rsp_difference_hundredths,
   output logic        rsp_failed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data
);

   localparam int F        = DISTANCE_FRACTION_BITS;
   localparam int DIM_BITS = $clog2(MAX_DIMENSION + 1);
   localparam int PW       = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
   localparam int DW       = PW + F;
   localparam int QW       = nid_pkg::X_BITS;
   localparam int SW       = 2 * F + 3;
   localparam int RB       = (SW + 1) / 2;
   localparam int MW0      = (F + 1 > DIM_BITS) ? F + 1 : DIM_BITS;
   localparam int MW       = (MW0 > nid_pkg::SUM_HALF) ? MW0 : nid_pkg::SUM_HALF;
   localparam int SUBW     = (DW + 1 > SW) ? DW + 1 : SW;
   localparam int CW       = $clog2(QW + 1);
   localparam int LW       = F + 9;
   localparam int SB       = nid_pkg::SUM_BITS;
   localparam int TB       = nid_pkg::TOL_BITS;

   nid_pkg::state_type state_ff, state_in;

   // Configuration registers.
   logic [12:0] width_ff, height_ff;
   logic        alpha_ff;
   logic [TB-1:0] tol_ff;

   // Captured pixel pair.
   logic [7:0] act_ff [4];
   logic [7:0] base_ff [4];
   logic       final_ff;
   logic [1:0] ch_ff;

   // Shared unit and sequencer data.
   logic [CW-1:0]   cnt_ff;
   logic [QW-1:0]   quo_ff;
   logic [DW-1:0]   rem_ff, div_ff;
   logic [2*MW-1:0] prod_ff;
   logic [SW-1:0]   s_ff, v_ff, res_ff, bit_ff;
   logic [SB-1:0]   sum_ff;
   logic [QW-1:0]   x_ff;
   logic [PW-1:0]   pix_ff;
   logic [7:0]      level_ff;

   // Output register.
   logic          rsp_valid_ff;
   logic [7:0]    rsp_level_ff;
   logic          rsp_report_ff;
   logic [TB-1:0] rsp_hund_ff;
   logic          rsp_failed_ff;

   logic req_accept;
   logic last_ch;
   logic out_free;

   // Shared subtractor.
   logic [SUBW-1:0] sub_a, sub_b;
   logic [SUBW:0]   sub_diff;
   logic            sub_borrow;

   // Shared multiplier.
   logic [MW-1:0] mul_a, mul_b;

   logic [7:0] cur_a, cur_b, cur_d, cur_m;
   logic [F:0] distance;
   logic [LW-1:0] dist255;
   logic [SB:0]   sum_add;
   logic [12:0]   cw_raw, chh_raw;
   logic [DIM_BITS-1:0] w_clamp, h_clamp;
   logic          pass, round_up;
   logic [TB-1:0] hund;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_ch    = (ch_ff == 2'd3) || (ch_ff == 2'd2 && !alpha_ff);

   assign cur_a = act_ff[ch_ff];
   assign cur_b = base_ff[ch_ff];
   assign cur_d = (cur_a >= cur_b) ? cur_a - cur_b : cur_b - cur_a;
   assign cur_m = cur_b[7] ? cur_b : 8'd255 - cur_b;

   assign distance = res_ff[F+1:1];
   assign dist255  = {distance, 8'b0} - LW'(distance);
   assign sum_add  = {1'b0, sum_ff} + (SB + 1)'(distance);

   // Dimensions: zero counts as one, oversize clamps to the maximum.
   always_comb begin
      cw_raw  = width_ff;
      chh_raw = height_ff;
      if (width_ff == 13'd0) begin
         w_clamp = DIM_BITS'(1);
      end else if (32'(width_ff) > 32'(MAX_DIMENSION)) begin
         w_clamp = DIM_BITS'(MAX_DIMENSION);
      end else begin
         w_clamp = DIM_BITS'(cw_raw);
      end
      if (height_ff == 13'd0) begin
         h_clamp = DIM_BITS'(1);
      end else if (32'(height_ff) > 32'(MAX_DIMENSION)) begin
         h_clamp = DIM_BITS'(MAX_DIMENSION);
      end else begin
         h_clamp = DIM_BITS'(chh_raw);
      end
   end

   // Operand selection for the shared subtractor.
   always_comb begin
      if (state_ff == nid_pkg::ST_ROOT) begin
         sub_a = SUBW'(v_ff);
         sub_b = SUBW'(res_ff + bit_ff);
      end else begin
         sub_a = SUBW'({rem_ff, quo_ff[QW-1]});
         sub_b = SUBW'(div_ff);
      end
      sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
      sub_borrow = sub_diff[SUBW];
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         nid_pkg::ST_PIX_MUL: begin
            mul_a = MW'(w_clamp);
            mul_b = MW'(h_clamp);
         end
         nid_pkg::ST_XLO_MUL: begin
            mul_a = MW'(sum_ff[nid_pkg::SUM_HALF-1:0]);
            mul_b = MW'(nid_pkg::PERCENT_SCALE);
         end
         nid_pkg::ST_XHI_MUL: begin
            mul_a = MW'(sum_ff[SB-1:nid_pkg::SUM_HALF]);
            mul_b = MW'(nid_pkg::PERCENT_SCALE);
         end
         default: begin
            mul_a = MW'(quo_ff[F:0]);
            mul_b = MW'(quo_ff[F:0]);
         end
      endcase
   end

   // Summary: round half up, saturate at full scale, at least one when failing.
   always_comb begin
      pass     = (quo_ff < QW'(tol_ff)) || (quo_ff == QW'(tol_ff) && rem_ff == '0);
      round_up = {rem_ff, 1'b0} >= {1'b0, div_ff};
      if (quo_ff >= QW'(nid_pkg::PERCENT_SCALE)) begin
         hund = TB'(nid_pkg::PERCENT_SCALE);
      end else begin
         hund = TB'(quo_ff) + TB'(round_up);
      end
      if (hund == '0) begin
         hund = TB'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nid_pkg::ST_IDLE:     if (req_accept) state_in = nid_pkg::ST_LOAD;
         nid_pkg::ST_LOAD:     state_in = nid_pkg::ST_RATIO;
         nid_pkg::ST_RATIO:    if (cnt_ff == CW'(1)) state_in = nid_pkg::ST_SQUARE;
         nid_pkg::ST_SQUARE:   state_in = nid_pkg::ST_ACCUM_SQ;
         nid_pkg::ST_ACCUM_SQ: state_in = last_ch ? nid_pkg::ST_ROOT : nid_pkg::ST_LOAD;
         nid_pkg::ST_ROOT:     if (cnt_ff == CW'(1)) state_in = nid_pkg::ST_LEVEL;
         nid_pkg::ST_LEVEL:    state_in = final_ff ? nid_pkg::ST_PIX_MUL : nid_pkg::ST_FINISH;
         nid_pkg::ST_PIX_MUL:  state_in = nid_pkg::ST_PIX_LOAD;
         nid_pkg::ST_PIX_LOAD: state_in = nid_pkg::ST_XLO_MUL;
         nid_pkg::ST_XLO_MUL:  state_in = nid_pkg::ST_XLO_ADD;
         nid_pkg::ST_XLO_ADD:  state_in = nid_pkg::ST_XHI_MUL;
         nid_pkg::ST_XHI_MUL:  state_in = nid_pkg::ST_XHI_ADD;
         nid_pkg::ST_XHI_ADD:  state_in = nid_pkg::ST_REPORT_DIV;
         nid_pkg::ST_REPORT_DIV: if (cnt_ff == CW'(1)) state_in = nid_pkg::ST_FINISH;
         nid_pkg::ST_FINISH:   if (out_free) state_in = nid_pkg::ST_IDLE;
         default:              state_in = nid_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = (state_ff != nid_pkg::ST_IDLE);
      csr_ready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nid_pkg::ST_IDLE;
         width_ff     <= 13'd1;
         height_ff    <= 13'd1;
         alpha_ff     <= 1'b0;
         tol_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               nid_pkg::REG_WIDTH:     width_ff  <= csr_data[12:0];
               nid_pkg::REG_HEIGHT:    height_ff <= csr_data[12:0];
               nid_pkg::REG_ALPHA:     alpha_ff  <= csr_data[0];
               nid_pkg::REG_TOLERANCE: tol_ff    <= csr_data[TB-1:0];
               default: ;
            endcase
         end
         if (state_ff == nid_pkg::ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (final_ff) begin
               sum_ff <= '0;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == nid_pkg::ST_LEVEL && dist255 >= (LW'(1) << F)) begin
            sum_ff <= sum_add[SB] ? {SB{1'b1}} : sum_add[SB-1:0];
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         nid_pkg::ST_IDLE: begin
            if (req_accept) begin
               act_ff[0]  <= req_actual_red;
               act_ff[1]  <= req_actual_green;
               act_ff[2]  <= req_actual_blue;
               act_ff[3]  <= req_actual_alpha;
               base_ff[0] <= req_base_red;
               base_ff[1] <= req_base_green;
               base_ff[2] <= req_base_blue;
               base_ff[3] <= req_base_alpha;
               final_ff   <= req_final_pixel;
               ch_ff      <= 2'd0;
               s_ff       <= '0;
            end
         end
         nid_pkg::ST_LOAD: begin
            quo_ff <= QW'(cur_d) << (QW - 8);
            rem_ff <= '0;
            div_ff <= DW'(cur_m);
            cnt_ff <= CW'(8 + F);
         end
         nid_pkg::ST_RATIO, nid_pkg::ST_REPORT_DIV: begin
            cnt_ff <= cnt_ff - CW'(1);
            if (!sub_borrow) begin
               rem_ff <= DW'(sub_diff);
               quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= DW'({rem_ff, quo_ff[QW-1]});
               quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
         end
         nid_pkg::ST_SQUARE: begin
            prod_ff <= mul_a * mul_b;
         end
         nid_pkg::ST_ACCUM_SQ: begin
            ch_ff <= ch_ff + 2'd1;
            s_ff  <= s_ff + SW'(prod_ff);
            // The root starts at the highest even bit of the sum's width.
            v_ff   <= s_ff + SW'(prod_ff);
            res_ff <= '0;
            bit_ff <= SW'(1) << (2 * RB - 2);
            cnt_ff <= CW'(RB);
         end
         nid_pkg::ST_ROOT: begin
            cnt_ff <= cnt_ff - CW'(1);
            bit_ff <= bit_ff >> 2;
            if (!sub_borrow) begin
               v_ff   <= SW'(sub_diff);
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
         end
         nid_pkg::ST_LEVEL: begin
            level_ff <= ((dist255 >> F) > LW'(255)) ? 8'd255 : 8'(dist255 >> F);
         end
         nid_pkg::ST_PIX_MUL, nid_pkg::ST_XLO_MUL, nid_pkg::ST_XHI_MUL: begin
            prod_ff <= mul_a * mul_b;
         end
         nid_pkg::ST_PIX_LOAD: begin
            pix_ff <= PW'(prod_ff);
         end
         nid_pkg::ST_XLO_ADD: begin
            x_ff <= QW'(prod_ff);
         end
         nid_pkg::ST_XHI_ADD: begin
            quo_ff <= x_ff + QW'({prod_ff, {nid_pkg::SUM_HALF{1'b0}}});
            rem_ff <= '0;
            div_ff <= DW'(pix_ff) << F;
            cnt_ff <= CW'(QW);
         end
         nid_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_level_ff  <= level_ff;
               rsp_report_ff <= final_ff;
               rsp_hund_ff   <= (final_ff && !pass) ? hund : '0;
               rsp_failed_ff <= final_ff && !pass;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_diff_level            = rsp_level_ff;
   assign rsp_report_valid          = rsp_report_ff;
   assign rsp_difference_hundredths = rsp_hund_ff;
   assign rsp_failed                = rsp_failed_ff;

   // A failing report always carries a nonzero difference.
   a_fail_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_report_valid && rsp_difference_hundredths != '0)
      else $error("failed report with zero difference");

   // An accepted item always starts the first channel divide.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == nid_pkg::ST_LOAD)
      else $error("accepted item did not start");

   // The output register is only loaded when it is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_diff_level))
      else $error("pending result overwritten");

   // The distance sum is cleared once the summary leaves.
   a_sum_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == nid_pkg::ST_FINISH && out_free && final_ff |=> sum_ff == '0)
      else $error("distance sum not cleared after final pixel");

endmodule
